/* sv/drrip_pkg.sv */
// Shared types and constants for the DRRIP replacement block.
// Field widths, register indexes, codes and the sequencer state type.
// No dependencies.
package drrip_pkg;

  // Fixed field widths
  localparam int unsigned SET_INDEX_W = 11;
  localparam int unsigned WAY_W       = 4;
  localparam int unsigned SEL_OUT_W   = 10;
  localparam int unsigned PHASE_W     = 32;
  localparam int unsigned STEP_W      = 10;
  localparam int unsigned BIP_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned RRV_W       = 2;
  localparam int unsigned CLASS_W     = 2;

  // Parameter defaults
  localparam int unsigned NUM_SETS_DEF           = 2048;
  localparam int unsigned NUM_WAYS_DEF           = 16;
  localparam int unsigned LEADERS_PER_POLICY_DEF = 32;
  localparam int unsigned SELECTOR_BITS_DEF      = 10;

  // Register reset values
  localparam logic [PHASE_W-1:0] PHASE_LENGTH_RST = 32'd100000;
  localparam logic [STEP_W-1:0]  SRRIP_STEP_RST   = 10'd10;
  localparam logic [BIP_W-1:0]   BIP_PERIOD_RST   = 8'd32;

  // Re-reference values
  localparam logic [RRV_W-1:0] RRV_MAX    = 2'd3;
  localparam logic [RRV_W-1:0] RRV_LONG   = 2'd2;
  localparam logic [RRV_W-1:0] RRV_NEAR   = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_LENGTH = 2'd0,
    CFG_SRRIP_STEP   = 2'd1,
    CFG_BIP_PERIOD   = 2'd2
  } drrip_cfg_e;

  typedef enum logic {
    CMD_VICTIM = 1'b0,
    CMD_UPDATE = 1'b1
  } drrip_cmd_e;

  typedef enum logic [CLASS_W-1:0] {
    CLASS_FOLLOWER = 2'd0,
    CLASS_SRRIP    = 2'd1,
    CLASS_BRRIP    = 2'd2
  } drrip_class_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_RD,
    ST_LOAD,
    ST_AGE,
    ST_PHASE,
    ST_PULL,
    ST_INSERT,
    ST_WRITE,
    ST_DONE
  } drrip_state_e;

endpackage

/* sv/drrip_if.sv */
// Request and response channel interfaces for the DRRIP replacement block.
// Valid/ready handshake with payload; widths from drrip_pkg.
interface drrip_req_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 cmd;
  logic [drrip_pkg::SET_INDEX_W-1:0]    set_index;
  logic [drrip_pkg::WAY_W-1:0]          way;
  logic                                 is_writeback;
  logic                                 hit;

  modport source (output valid, cmd, set_index, way, is_writeback, hit, input ready);
  modport sink   (input valid, cmd, set_index, way, is_writeback, hit, output ready);
endinterface

interface drrip_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [drrip_pkg::WAY_W-1:0]          victim_way;
  logic [drrip_pkg::SEL_OUT_W-1:0]      selector_value;

  modport source (output valid, victim_way, selector_value, input ready);
  modport sink   (input valid, victim_way, selector_value, output ready);
endinterface

/* sv/drrip_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module drrip_ram #(
  parameter int unsigned Width = 34,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/drrip_cache_replacement.sv */
// DRRIP replacement state: one request at a time under a small sequencer.
// A victim search reads the set and ages it round by round until a way holds three; an update
// advances the phase counter, pulls the selector when the phase wraps and inserts. Below 2048
// sets the set index is first reduced step by step. A request is taken only once the last
// result is registered. Reset sweeps the set RAM one set per cycle (all ways three, leader
// class); ready stays low meanwhile. Depends on drrip_pkg, drrip_if.sv and drrip_ram.
module drrip_cache_replacement #(
  parameter int unsigned NUM_SETS           = drrip_pkg::NUM_SETS_DEF,
  parameter int unsigned NUM_WAYS           = drrip_pkg::NUM_WAYS_DEF,
  parameter int unsigned LEADERS_PER_POLICY = drrip_pkg::LEADERS_PER_POLICY_DEF,
  parameter int unsigned SELECTOR_BITS      = drrip_pkg::SELECTOR_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  drrip_req_if.sink                           req,
  drrip_rsp_if.source                         rsp,
  input  logic                                cfg_we_i,
  input  logic [drrip_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [drrip_pkg::CFG_DATA_W-1:0]    cfg_wdata_i
);

  localparam int unsigned SetW   = $clog2(NUM_SETS);
  localparam int unsigned WordW  = NUM_WAYS * drrip_pkg::RRV_W + drrip_pkg::CLASS_W;
  localparam int unsigned RrvW   = NUM_WAYS * drrip_pkg::RRV_W;
  localparam int unsigned WayIdW = $clog2(NUM_WAYS);
  localparam int unsigned SelW   = SELECTOR_BITS;
  localparam int unsigned SelMax = (1 << SELECTOR_BITS) - 1;
  localparam int unsigned SelMid = SelMax / 2;
  localparam int unsigned SumW   = ((SelW > drrip_pkg::STEP_W) ? SelW : drrip_pkg::STEP_W) + 1;
  // Leader layout: one BRRIP and one SRRIP leader in each of the first LEADERS_PER_POLICY groups of TwoR sets
  localparam int unsigned Rq     = NUM_SETS / (2 * LEADERS_PER_POLICY);
  localparam int unsigned Rr     = (Rq == 0) ? 1 : Rq;
  localparam int unsigned TwoR   = 2 * Rr;
  localparam int unsigned MW     = $clog2(TwoR);
  localparam int unsigned LeaderSpan = LEADERS_PER_POLICY * TwoR;
  // Set index reduction by restoring subtraction when the index can exceed the set count
  localparam int unsigned IdxRange  = 1 << drrip_pkg::SET_INDEX_W;
  localparam bit          ModNeeded = (NUM_SETS < IdxRange);
  localparam int unsigned KTop      = ModNeeded ? $clog2((IdxRange + NUM_SETS - 1) / NUM_SETS) : 0;
  localparam int unsigned DivTop    = ModNeeded ? (NUM_SETS << KTop) : 0;
  localparam int unsigned DivW      = drrip_pkg::SET_INDEX_W + 2;
  localparam int unsigned CntW      = 3;

  drrip_pkg::drrip_state_e state_q, state_d;

  // Control and architectural state
  logic [SetW-1:0]                   clr_q, clr_d;
  logic [MW-1:0]                     m_q, m_d;
  logic                              out_valid_q, out_valid_d;
  logic [SelW-1:0]                   sel_q, sel_d;
  logic [drrip_pkg::BIP_W-1:0]       bim_q, bim_d;
  logic [drrip_pkg::PHASE_W-1:0]     phase_q, phase_d;
  logic [drrip_pkg::PHASE_W-1:0]     len_q, len_d;
  logic [drrip_pkg::STEP_W-1:0]      step_q, step_d;
  logic [drrip_pkg::BIP_W-1:0]       bip_q, bip_d;

  // Per-request working registers
  logic                              cmd_q, cmd_d;
  logic [drrip_pkg::WAY_W-1:0]       way_q, way_d;
  logic                              wb_q, wb_d;
  logic                              hit_q, hit_d;
  logic [drrip_pkg::SET_INDEX_W-1:0] rem_q, rem_d;
  logic [DivW-1:0]                   div_q, div_d;
  logic [CntW-1:0]                   cnt_q, cnt_d;
  logic [WordW-1:0]                  word_q, word_d;
  logic [drrip_pkg::WAY_W-1:0]       victim_q, victim_d;
  logic [drrip_pkg::WAY_W-1:0]       out_victim_q, out_victim_d;
  logic [drrip_pkg::SEL_OUT_W-1:0]   out_sel_q, out_sel_d;

  // RAM port
  logic              ram_we, ram_re;
  logic [SetW-1:0]   ram_waddr, ram_raddr;
  logic [WordW-1:0]  ram_wdata, ram_rdata;
  logic [SetW-1:0]   set_addr;

  // Shared datapath signals
  logic                          any3;
  logic [WayIdW-1:0]             first3;
  logic [WordW-1:0]              aged;
  logic [drrip_pkg::PHASE_W-1:0] phase_inc;
  logic                          phase_wrap;
  logic [SelW-1:0]               sel_pull, pull_x;
  logic [SelW-1:0]               sel_ins;
  logic [SumW-1:0]               sel_sum;
  logic [drrip_pkg::BIP_W-1:0]   bim_inc, bim_ins;
  logic                          bim_match, use_bim;
  logic [drrip_pkg::RRV_W-1:0]   ins_v;
  logic [WordW-1:0]              word_ins;
  drrip_pkg::drrip_class_e       set_class, clr_class;
  logic                          out_space;

  assign set_addr  = SetW'(rem_q);
  assign set_class = drrip_pkg::drrip_class_e'(word_q[WordW-1 -: drrip_pkg::CLASS_W]);
  assign out_space = !out_valid_q || rsp.ready;

  // Ageing round over the whole set word
  always_comb begin
    any3   = 1'b0;
    first3 = '0;
    aged   = word_q;
    for (int w = 0; w < NUM_WAYS; w++) begin
      any3 = any3 | (word_q[2*w +: 2] == drrip_pkg::RRV_MAX);
      aged[2*w +: 2] = word_q[2*w +: 2] + 2'd1;
    end
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (word_q[2*w +: 2] == drrip_pkg::RRV_MAX) begin
        first3 = WayIdW'(w);
      end
    end
  end

  // Phase counter and selector pull toward the midpoint
  assign phase_inc  = phase_q + 32'd1;
  assign phase_wrap = (phase_inc >= len_q);

  always_comb begin
    if (sel_q > SelW'(SelMid)) begin
      pull_x   = sel_q - (sel_q >> 2);
      sel_pull = (pull_x < SelW'(SelMid)) ? pull_x : SelW'(SelMid);
    end else begin
      pull_x   = sel_q + ((SelW'(SelMax) - sel_q) >> 2);
      sel_pull = (pull_x > SelW'(SelMid)) ? pull_x : SelW'(SelMid);
    end
  end

  // Insertion value and selector training
  assign bim_inc   = bim_q + 8'd1;
  assign bim_match = (bim_inc == bip_q);
  assign sel_sum   = SumW'(sel_q) + SumW'(step_q);

  always_comb begin
    ins_v   = drrip_pkg::RRV_MAX;
    sel_ins = sel_q;
    use_bim = 1'b0;
    if (wb_q) begin
      ins_v = drrip_pkg::RRV_LONG;
    end else if (hit_q) begin
      ins_v = drrip_pkg::RRV_NEAR;
    end else begin
      case (set_class)
        drrip_pkg::CLASS_BRRIP: begin
          if (sel_q != '0) begin
            sel_ins = sel_q - SelW'(1);
          end
          use_bim = 1'b1;
        end
        drrip_pkg::CLASS_SRRIP: begin
          sel_ins = (sel_sum > SumW'(SelMax)) ? SelW'(SelMax) : SelW'(sel_sum);
          ins_v   = drrip_pkg::RRV_LONG;
        end
        default: begin
          if (sel_q <= SelW'(SelMid)) begin
            ins_v = drrip_pkg::RRV_LONG;
          end else begin
            use_bim = 1'b1;
          end
        end
      endcase
    end
    bim_ins = bim_q;
    if (use_bim) begin
      bim_ins = bim_match ? '0 : bim_inc;
      ins_v   = bim_match ? drrip_pkg::RRV_LONG : drrip_pkg::RRV_MAX;
    end
  end

  always_comb begin
    word_ins = word_q;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (32'(way_q) == 32'(w)) begin
        word_ins[2*w +: 2] = ins_v;
      end
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      drrip_pkg::ST_CLEAR: begin
        if (clr_q == SetW'(NUM_SETS - 1)) state_d = drrip_pkg::ST_IDLE;
      end
      drrip_pkg::ST_IDLE: begin
        if (req.valid) state_d = ModNeeded ? drrip_pkg::ST_MOD : drrip_pkg::ST_RD;
      end
      drrip_pkg::ST_MOD: begin
        if (cnt_q == '0) state_d = drrip_pkg::ST_RD;
      end
      drrip_pkg::ST_RD:   state_d = drrip_pkg::ST_LOAD;
      drrip_pkg::ST_LOAD: begin
        state_d = (cmd_q == drrip_pkg::CMD_VICTIM) ? drrip_pkg::ST_AGE : drrip_pkg::ST_PHASE;
      end
      drrip_pkg::ST_AGE: begin
        if (any3) state_d = drrip_pkg::ST_WRITE;
      end
      drrip_pkg::ST_PHASE: begin
        state_d = phase_wrap ? drrip_pkg::ST_PULL : drrip_pkg::ST_INSERT;
      end
      drrip_pkg::ST_PULL:   state_d = drrip_pkg::ST_INSERT;
      drrip_pkg::ST_INSERT: state_d = drrip_pkg::ST_WRITE;
      drrip_pkg::ST_WRITE:  state_d = drrip_pkg::ST_DONE;
      drrip_pkg::ST_DONE: begin
        if (out_space) state_d = drrip_pkg::ST_IDLE;
      end
      default: state_d = drrip_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = set_addr;
    ram_raddr = set_addr;
    ram_wdata = word_q;
    req.ready = 1'b0;
    clr_class = drrip_pkg::CLASS_FOLLOWER;
    if (32'(clr_q) < LeaderSpan) begin
      if (m_q == '0) begin
        clr_class = drrip_pkg::CLASS_BRRIP;
      end else if (m_q == MW'(Rr)) begin
        clr_class = drrip_pkg::CLASS_SRRIP;
      end
    end
    unique case (state_q)
      drrip_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = {clr_class, {RrvW{1'b1}}};
      end
      drrip_pkg::ST_IDLE:  req.ready = 1'b1;
      drrip_pkg::ST_RD:    ram_re    = 1'b1;
      drrip_pkg::ST_WRITE: ram_we    = 1'b1;
      default: ;
    endcase
  end

  // Datapath and register next values
  always_comb begin
    clr_d        = clr_q;
    m_d          = m_q;
    sel_d        = sel_q;
    bim_d        = bim_q;
    phase_d      = phase_q;
    len_d        = len_q;
    step_d       = step_q;
    bip_d        = bip_q;
    cmd_d        = cmd_q;
    way_d        = way_q;
    wb_d         = wb_q;
    hit_d        = hit_q;
    rem_d        = rem_q;
    div_d        = div_q;
    cnt_d        = cnt_q;
    word_d       = word_q;
    victim_d     = victim_q;
    out_victim_d = out_victim_q;
    out_sel_d    = out_sel_q;
    out_valid_d  = out_valid_q && !rsp.ready;

    if (cfg_we_i) begin
      unique case (drrip_pkg::drrip_cfg_e'(cfg_idx_i))
        drrip_pkg::CFG_PHASE_LENGTH: len_d  = cfg_wdata_i;
        drrip_pkg::CFG_SRRIP_STEP:   step_d = cfg_wdata_i[drrip_pkg::STEP_W-1:0];
        drrip_pkg::CFG_BIP_PERIOD:   bip_d  = cfg_wdata_i[drrip_pkg::BIP_W-1:0];
        default: ;
      endcase
    end

    unique case (state_q)
      drrip_pkg::ST_CLEAR: begin
        clr_d = clr_q + SetW'(1);
        m_d   = (m_q == MW'(TwoR - 1)) ? '0 : m_q + MW'(1);
      end
      drrip_pkg::ST_IDLE: begin
        if (req.valid) begin
          cmd_d    = req.cmd;
          way_d    = req.way;
          wb_d     = req.is_writeback;
          hit_d    = req.hit;
          rem_d    = req.set_index;
          div_d    = DivW'(DivTop);
          cnt_d    = CntW'(KTop);
          victim_d = '0;
        end
      end
      drrip_pkg::ST_MOD: begin
        if (DivW'(rem_q) >= div_q) begin
          rem_d = rem_q - drrip_pkg::SET_INDEX_W'(div_q);
        end
        div_d = div_q >> 1;
        cnt_d = cnt_q - CntW'(1);
      end
      drrip_pkg::ST_LOAD: word_d = ram_rdata;
      drrip_pkg::ST_AGE: begin
        if (any3) begin
          victim_d = drrip_pkg::WAY_W'(first3);
        end else begin
          word_d = aged;
        end
      end
      drrip_pkg::ST_PHASE: phase_d = phase_wrap ? '0 : phase_inc;
      drrip_pkg::ST_PULL:  sel_d   = sel_pull;
      drrip_pkg::ST_INSERT: begin
        sel_d  = sel_ins;
        bim_d  = bim_ins;
        word_d = word_ins;
      end
      drrip_pkg::ST_DONE: begin
        if (out_space) begin
          out_valid_d  = 1'b1;
          out_victim_d = victim_q;
          out_sel_d    = drrip_pkg::SEL_OUT_W'(sel_q);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= drrip_pkg::ST_CLEAR;
      clr_q       <= '0;
      m_q         <= '0;
      out_valid_q <= 1'b0;
      sel_q       <= SelW'(SelMid);
      bim_q       <= '0;
      phase_q     <= '0;
      len_q       <= drrip_pkg::PHASE_LENGTH_RST;
      step_q      <= drrip_pkg::SRRIP_STEP_RST;
      bip_q       <= drrip_pkg::BIP_PERIOD_RST;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      m_q         <= m_d;
      out_valid_q <= out_valid_d;
      sel_q       <= sel_d;
      bim_q       <= bim_d;
      phase_q     <= phase_d;
      len_q       <= len_d;
      step_q      <= step_d;
      bip_q       <= bip_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    way_q        <= way_d;
    wb_q         <= wb_d;
    hit_q        <= hit_d;
    rem_q        <= rem_d;
    div_q        <= div_d;
    cnt_q        <= cnt_d;
    word_q       <= word_d;
    victim_q     <= victim_d;
    out_victim_q <= out_victim_d;
    out_sel_q    <= out_sel_d;
  end

  drrip_ram #(
    .Width (WordW),
    .Depth (NUM_SETS)
  ) u_set_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rsp.valid          = out_valid_q;
  assign rsp.victim_way     = out_victim_q;
  assign rsp.selector_value = out_sel_q;

endmodule

/* bench/tb.sv */
// Testbench for drrip_cache_replacement: victim search, RRV updates, set dueling and
// selector pulls, checked against a predictor kept inside the bench.
// Depends on drrip_pkg, drrip_if.sv and the block itself.
module tb;

  localparam int unsigned NUM_SETS   = drrip_pkg::NUM_SETS_DEF;
  localparam int unsigned NUM_WAYS   = drrip_pkg::NUM_WAYS_DEF;
  localparam int unsigned LEAD_PER   = drrip_pkg::LEADERS_PER_POLICY_DEF;
  localparam int unsigned SEL_MAX    = (1 << drrip_pkg::SELECTOR_BITS_DEF) - 1;
  localparam int unsigned SEL_MID    = SEL_MAX / 2;
  localparam int unsigned SET_STRIDE =
    (NUM_SETS / (2 * LEAD_PER)) == 0 ? 1 : NUM_SETS / (2 * LEAD_PER);
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned HOT_SETS     = 8;
  localparam int unsigned WAY_BITS     = drrip_pkg::WAY_W;
  localparam int unsigned IDX_BITS     = drrip_pkg::SET_INDEX_W;
  localparam int unsigned RRV_BITS     = drrip_pkg::RRV_W;
  localparam int unsigned SEL_BITS     = drrip_pkg::SEL_OUT_W;

  typedef struct packed {
    logic [drrip_pkg::WAY_W-1:0]     victim_way;
    logic [drrip_pkg::SEL_OUT_W-1:0] selector_value;
  } drrip_result_t;

  typedef struct packed {
    drrip_pkg::drrip_cmd_e             cmd;
    logic [drrip_pkg::SET_INDEX_W-1:0] set_index;
    logic [drrip_pkg::WAY_W-1:0]       way;
    logic                              is_writeback;
    logic                              hit;
  } drrip_req_t;

  logic                             clk_i;
  logic                             rst_ni;
  logic                             cfg_we_i;
  logic [drrip_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [drrip_pkg::CFG_DATA_W-1:0] cfg_wdata_i;

  drrip_req_if req_ch ();
  drrip_rsp_if rsp_ch ();

  drrip_cache_replacement dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req         (req_ch),
    .rsp         (rsp_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predictor state
  logic [2*NUM_WAYS-1:0]           rrv_mem [NUM_SETS];
  logic [drrip_pkg::SEL_OUT_W-1:0] sel_m;
  logic [drrip_pkg::BIP_W-1:0]     bip_count_m;
  logic [drrip_pkg::PHASE_W-1:0]   phase_count_m;
  logic [drrip_pkg::PHASE_W-1:0]   phase_len_m;
  logic [drrip_pkg::STEP_W-1:0]    step_m;
  logic [drrip_pkg::BIP_W-1:0]     bip_period_m;

  drrip_result_t owed_results[$];
  int unsigned   fail_count;
  int unsigned   send_idle_pct;
  int unsigned   rsp_stall_pct;
  int unsigned   hold_asks;

  // Mix of BRRIP leaders, SRRIP leaders and followers that the random part dwells on
  logic [drrip_pkg::SET_INDEX_W-1:0] hot_sets [HOT_SETS] =
    '{0, 64, 1984, 32, 2016, 1, 1000, 2047};

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #3200000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic drrip_pkg::drrip_class_e set_class(int unsigned s);
    int unsigned q, m;
    q = s / (2 * SET_STRIDE);
    m = s % (2 * SET_STRIDE);
    if (q >= LEAD_PER) return drrip_pkg::CLASS_FOLLOWER;
    if (m == 0) return drrip_pkg::CLASS_BRRIP;
    if (m == SET_STRIDE) return drrip_pkg::CLASS_SRRIP;
    return drrip_pkg::CLASS_FOLLOWER;
  endfunction

  function automatic logic [drrip_pkg::RRV_W-1:0] bimodal_insert();
    bip_count_m = bip_count_m + 1'b1; // wraps at 256
    if (bip_count_m == bip_period_m) begin
      bip_count_m = '0;
      return drrip_pkg::RRV_LONG;
    end
    return drrip_pkg::RRV_MAX;
  endfunction

  function automatic drrip_result_t predict_replacement(drrip_req_t r);
    drrip_result_t               res;
    int unsigned                 s, top, age, sel, x;
    logic [drrip_pkg::RRV_W-1:0] v;
    logic [2*NUM_WAYS-1:0]       word;
    s = r.set_index % NUM_SETS;
    res.victim_way = '0;
    if (r.cmd == drrip_pkg::CMD_VICTIM) begin
      word = rrv_mem[s];
      top = 0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (word[2*w +: 2] > top) top = word[2*w +: 2];
      end
      // age the whole set so that the oldest way reaches the maximum
      age = drrip_pkg::RRV_MAX - top;
      for (int w = 0; w < NUM_WAYS; w++) word[2*w +: 2] = word[2*w +: 2] + RRV_BITS'(age);
      for (int w = NUM_WAYS - 1; w >= 0; w--) begin
        if (word[2*w +: 2] == drrip_pkg::RRV_MAX) res.victim_way = WAY_BITS'(w);
      end
      rrv_mem[s] = word;
    end else begin
      phase_count_m = phase_count_m + 1'b1;
      sel = sel_m;
      if (phase_count_m >= phase_len_m) begin
        phase_count_m = '0;
        if (sel > SEL_MID) begin
          x = sel - sel / 4;
          sel = x < SEL_MID ? x : SEL_MID;
        end else begin
          x = sel + (SEL_MAX - sel) / 4;
          sel = x > SEL_MID ? x : SEL_MID;
        end
      end
      if (r.is_writeback) begin
        v = drrip_pkg::RRV_LONG;
      end else if (r.hit) begin
        v = drrip_pkg::RRV_NEAR;
      end else begin
        case (set_class(s))
          drrip_pkg::CLASS_BRRIP: begin
            if (sel > 0) sel--;
            v = bimodal_insert();
          end
          drrip_pkg::CLASS_SRRIP: begin
            sel = sel + step_m;
            if (sel > SEL_MAX) sel = SEL_MAX;
            v = drrip_pkg::RRV_LONG;
          end
          default: begin
            v = (sel <= SEL_MID) ? drrip_pkg::RRV_LONG : bimodal_insert();
          end
        endcase
      end
      sel_m = SEL_BITS'(sel);
      if (r.way < NUM_WAYS) rrv_mem[s][2*r.way +: 2] = v;
    end
    res.selector_value = sel_m;
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    if (fail_count < 100) $display("mismatch: %s got %0d want %0d", what, got, want);
    fail_count++;
  endtask

  always @(posedge clk_i) begin : check_results
    drrip_result_t want;
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("unexpected result, victim_way", rsp_ch.victim_way, 0);
      end else begin
        want = owed_results.pop_front();
        if (rsp_ch.victim_way !== want.victim_way)
          report_mismatch("victim_way", rsp_ch.victim_way, want.victim_way);
        if (rsp_ch.selector_value !== want.selector_value)
          report_mismatch("selector_value", rsp_ch.selector_value, want.selector_value);
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off
  initial begin : drive_rsp_ready
    int unsigned hold_left, holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (holds_seen != hold_asks) begin
        holds_seen = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // valid stays high after acceptance; the next call either idles or replaces the request
  task automatic send_request(drrip_req_t r);
    drrip_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid        <= 1'b1;
    req_ch.cmd          <= r.cmd;
    req_ch.set_index    <= r.set_index;
    req_ch.way          <= r.way;
    req_ch.is_writeback <= r.is_writeback;
    req_ch.hit          <= r.hit;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    res = predict_replacement(r);
    owed_results.insert(owed_results.size(), res);
  endtask

  task automatic send_fields(drrip_pkg::drrip_cmd_e cmd, int unsigned set, int unsigned way,
                             bit wb, bit hit);
    drrip_req_t r;
    r.cmd          = cmd;
    r.set_index    = IDX_BITS'(set);
    r.way          = WAY_BITS'(way);
    r.is_writeback = wb;
    r.hit          = hit;
    send_request(r);
  endtask

  task automatic wait_drain();
    req_ch.valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(drrip_pkg::drrip_cfg_e idx, logic [drrip_pkg::CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      drrip_pkg::CFG_PHASE_LENGTH: phase_len_m  = data;
      drrip_pkg::CFG_SRRIP_STEP:   step_m       = data[drrip_pkg::STEP_W-1:0];
      drrip_pkg::CFG_BIP_PERIOD:   bip_period_m = data[drrip_pkg::BIP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(logic [drrip_pkg::PHASE_W-1:0] len,
                           logic [drrip_pkg::STEP_W-1:0] step,
                           logic [drrip_pkg::BIP_W-1:0] period);
    write_reg(drrip_pkg::CFG_PHASE_LENGTH, len);
    write_reg(drrip_pkg::CFG_SRRIP_STEP, 32'(step));
    write_reg(drrip_pkg::CFG_BIP_PERIOD, 32'(period));
  endtask

  function automatic drrip_req_t random_request(int unsigned brrip_pct);
    drrip_req_t r;
    r.cmd          = $urandom_range(1) ? drrip_pkg::CMD_UPDATE : drrip_pkg::CMD_VICTIM;
    r.way          = WAY_BITS'($urandom_range(15));
    r.is_writeback = ($urandom_range(4) == 0);
    r.hit          = 1'($urandom_range(1));
    if ($urandom_range(99) < brrip_pct) begin
      // miss in a BRRIP leader drags the selector down
      r.cmd          = drrip_pkg::CMD_UPDATE;
      r.is_writeback = 1'b0;
      r.hit          = 1'b0;
      r.set_index    = hot_sets[$urandom_range(2)];
    end else if ($urandom_range(3) != 0) begin
      r.set_index = hot_sets[$urandom_range(HOT_SETS - 1)];
    end else begin
      r.set_index = IDX_BITS'($urandom_range(NUM_SETS - 1));
    end
    return r;
  endfunction

  // Mostly single requests; now and then a run of hits, some of them writebacks, over every way
  // of a hot set followed by a victim search, so that the set must age before a way reaches three.
  task automatic run_random(int unsigned n, int unsigned brrip_pct);
    int unsigned sent, set;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(9) == 0) begin
        set = hot_sets[$urandom_range(HOT_SETS - 1)];
        for (int w = 0; w < NUM_WAYS; w++)
          send_fields(drrip_pkg::CMD_UPDATE, set, w, $urandom_range(7) == 0, 1'b1);
        send_fields(drrip_pkg::CMD_VICTIM, set, $urandom_range(15),
                    1'($urandom_range(1)), 1'($urandom_range(1)));
        sent += NUM_WAYS + 1;
      end else begin
        send_request(random_request(brrip_pct));
        sent++;
      end
    end
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    // ignored fields at all ones on a victim search
    send_fields(drrip_pkg::CMD_VICTIM, 0, 15, 1'b1, 1'b1);
    send_fields(drrip_pkg::CMD_VICTIM, 2047, 0, 1'b0, 1'b0);
    send_fields(drrip_pkg::CMD_UPDATE, 2047, 0, 1'b0, 1'b1);
    // writeback wins over hit
    send_fields(drrip_pkg::CMD_UPDATE, 2047, 15, 1'b1, 1'b1);
    send_fields(drrip_pkg::CMD_VICTIM, 2047, 0, 1'b0, 1'b0);
    send_fields(drrip_pkg::CMD_UPDATE, 0, 15, 1'b0, 1'b0);
    send_fields(drrip_pkg::CMD_UPDATE, 32, 0, 1'b0, 1'b0);
    send_fields(drrip_pkg::CMD_UPDATE, 1, 3, 1'b0, 1'b0);
    for (int i = 0; i < 10; i++) send_fields(drrip_pkg::CMD_UPDATE, 64, i, 1'b0, 1'b0);
    // selector now below midpoint: follower misses insert as SRRIP
    send_fields(drrip_pkg::CMD_UPDATE, 1, 4, 1'b0, 1'b0);
    send_fields(drrip_pkg::CMD_UPDATE, 1, 5, 1'b1, 1'b0);
    send_fields(drrip_pkg::CMD_VICTIM, 1, 0, 1'b0, 1'b0);
    wait_drain();
    write_reg(drrip_pkg::CFG_PHASE_LENGTH, 32'd1);
    send_fields(drrip_pkg::CMD_UPDATE, 2016, 7, 1'b0, 1'b0);
    send_fields(drrip_pkg::CMD_UPDATE, 1984, 8, 1'b0, 1'b1);
    send_fields(drrip_pkg::CMD_VICTIM, 1984, 0, 1'b0, 1'b0);
    wait_drain();
  endtask

  task automatic test_no_idling();
    load_regs(32'd0, 10'd1023, 8'd5);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    run_random(250, 5);
    wait_drain();
  endtask

  task automatic test_sender_idle();
    load_regs(32'd7, 10'd37, 8'd255);
    send_idle_pct = 81;
    rsp_stall_pct = 0;
    run_random(250, 10);
    wait_drain();
  endtask

  task automatic test_receiver_stall();
    // long phase, no SRRIP push: BRRIP misses drive the selector to zero
    load_regs(32'hFFFF_FFFF, 10'd0, 8'd0);
    send_idle_pct = 0;
    rsp_stall_pct = 81;
    run_random(450, 90);
    wait_drain();
  endtask

  task automatic test_both_idle();
    load_regs(32'd1, 10'd1, 8'd1);
    send_idle_pct = 36;
    rsp_stall_pct = 36;
    run_random(250, 60);
    wait_drain();
  endtask

  task automatic test_backpressure();
    load_regs(32'd3, 10'd500, 8'd3);
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_asks++;
    run_random(120, 20);
    wait_drain();
  endtask

  initial begin
    fail_count    = 0;
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    hold_asks     = 0;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = drrip_pkg::CFG_PHASE_LENGTH;
    cfg_wdata_i   = '0;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = drrip_pkg::CMD_VICTIM;
    req_ch.set_index    = '0;
    req_ch.way          = '0;
    req_ch.is_writeback = 1'b0;
    req_ch.hit          = 1'b0;
    for (int s = 0; s < NUM_SETS; s++) rrv_mem[s] = '1;
    sel_m         = SEL_BITS'(SEL_MID);
    bip_count_m   = '0;
    phase_count_m = '0;
    phase_len_m   = drrip_pkg::PHASE_LENGTH_RST;
    step_m        = drrip_pkg::SRRIP_STEP_RST;
    bip_period_m  = drrip_pkg::BIP_PERIOD_RST;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
